>>> hdl/sync_length_sum_frame_parser_top_assert.svh
// Assertion macros for the frame parser modules, used by the drain side.
`ifndef SYNC_LENGTH_SUM_FRAME_PARSER_TOP_ASSERT_SVH
`define SYNC_LENGTH_SUM_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SLP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/slp_pkg.sv
// Types and constants of the frame parser.
package slp_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int IDX_W  = 5;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'hAF;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [2:0] {
    PH_SYNC1 = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_FETCH = 2'd1,
    BK_LOAD  = 2'd2,
    BK_EMPTY = 2'd3
  } back_state_t;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] msg_id;
    logic [LEN_W-1:0]  data_len;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              last;
  } result_t;

  // Good frame handed from the parser to the drain side.
  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
  } frame_cmd_t;

  // Payload buffer write from the parser.
  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  addr;
    logic [BYTE_W-1:0] data;
  } buf_wr_t;

endpackage

>>> hdl/slp_front.sv
// Frame parser front end: hunt, header, payload capture and checksum test.
module slp_front #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [slp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slp_pkg::BYTE_W-1:0]      cfg_value,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  slp_pkg::item_t                  item,
  input  logic                            drain_busy,
  input  logic                            q_full,
  output logic                            q_push,
  output slp_pkg::frame_cmd_t             q_cmd,
  output slp_pkg::buf_wr_t                wr
);

  slp_pkg::phase_t             phase, phase_next;
  logic [slp_pkg::BYTE_W-1:0]  frame_id, frame_id_next;
  logic [slp_pkg::LEN_W-1:0]   frame_length, frame_length_next;
  logic [slp_pkg::LEN_W-1:0]   fill_index, fill_index_next;
  logic [slp_pkg::BYTE_W-1:0]  running_sum, running_sum_next;
  logic [slp_pkg::BYTE_W-1:0]  sync_first, sync_second;
  logic [slp_pkg::BYTE_W-1:0]  c;
  logic [slp_pkg::LEN_W-1:0]   fill_inc;
  logic                        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= slp_pkg::SYNC_FIRST_RESET;
      sync_second <= slp_pkg::SYNC_SECOND_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        slp_pkg::REG_SYNC_FIRST:  sync_first  <= cfg_value;
        slp_pkg::REG_SYNC_SECOND: sync_second <= cfg_value;
        default: ;
      endcase
    end
  end

  // Payload bytes wait while the buffer still holds an undrained frame; checksum bytes wait while the queue is full.
  assign item_stall = ((phase == slp_pkg::PH_DATA) && drain_busy) ||
                      ((phase == slp_pkg::PH_CSUM) && q_full);
  assign accept     = item_valid && !item_stall;
  assign c          = item.rx_byte;
  assign fill_inc   = fill_index + slp_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= slp_pkg::PH_SYNC1;
      frame_id     <= '0;
      frame_length <= '0;
      fill_index   <= '0;
      running_sum  <= '0;
    end else begin
      phase        <= phase_next;
      frame_id     <= frame_id_next;
      frame_length <= frame_length_next;
      fill_index   <= fill_index_next;
      running_sum  <= running_sum_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_id_next     = frame_id;
    frame_length_next = frame_length;
    fill_index_next   = fill_index;
    running_sum_next  = running_sum;
    q_push            = 1'b0;
    q_cmd.id          = frame_id;
    q_cmd.len         = frame_length;
    wr.en             = 1'b0;
    wr.addr           = fill_index;
    wr.data           = c;
    if (accept) begin
      if (item.cmd == slp_pkg::CMD_TIMEOUT) begin
        phase_next = slp_pkg::PH_SYNC1;
      end else begin
        unique case (phase)
          slp_pkg::PH_SYNC2: begin
            phase_next       = (c == sync_second) ? slp_pkg::PH_ID : slp_pkg::PH_SYNC1;
            running_sum_next = running_sum + c;
          end
          slp_pkg::PH_ID: begin
            frame_id_next    = c;
            running_sum_next = running_sum + c;
            phase_next       = slp_pkg::PH_LEN;
          end
          slp_pkg::PH_LEN: begin
            if (c <= slp_pkg::BYTE_W'(MAX_PAYLOAD)) begin
              frame_length_next = c[slp_pkg::LEN_W-1:0];
              fill_index_next   = '0;
              running_sum_next  = running_sum + c;
              phase_next        = (c != '0) ? slp_pkg::PH_DATA : slp_pkg::PH_CSUM;
            end else begin
              phase_next = slp_pkg::PH_SYNC1;
            end
          end
          slp_pkg::PH_DATA: begin
            wr.en            = 1'b1;
            fill_index_next  = fill_inc;
            running_sum_next = running_sum + c;
            if (fill_inc >= frame_length) begin
              phase_next = slp_pkg::PH_CSUM;
            end
          end
          slp_pkg::PH_CSUM: begin
            q_push     = (running_sum == c);
            phase_next = slp_pkg::PH_SYNC1;
          end
          default: begin
            // hunting: every byte restarts the sum
            phase_next       = (c == sync_first) ? slp_pkg::PH_SYNC2 : slp_pkg::PH_SYNC1;
            running_sum_next = c;
          end
        endcase
      end
    end
  end

endmodule

>>> hdl/slp_queue.sv
// Short queue of good frames between the parser and the drain side.
module slp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  slp_pkg::frame_cmd_t push_cmd,
  input  logic                pop,
  output slp_pkg::frame_cmd_t head,
  output logic                empty,
  output logic                full
);

  slp_pkg::frame_cmd_t             entries [slp_pkg::QUEUE_DEPTH];
  logic [slp_pkg::QPTR_W-1:0]      wptr, rptr;
  logic [slp_pkg::QPTR_W:0]        count;

  assign head  = entries[rptr];
  assign empty = (count == '0);
  assign full  = (count == (slp_pkg::QPTR_W + 1)'(slp_pkg::QUEUE_DEPTH));

  function automatic logic [slp_pkg::QPTR_W-1:0] ptr_inc(input logic [slp_pkg::QPTR_W-1:0] p);
    ptr_inc = (p == slp_pkg::QPTR_W'(slp_pkg::QUEUE_DEPTH - 1)) ? '0 :
              p + slp_pkg::QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop) begin
        rptr <= ptr_inc(rptr);
      end
      if (push && !pop) begin
        count <= count + (slp_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (slp_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

>>> hdl/slp_back.sv
// Drain side: payload buffer and result sequencer.
`include "sync_length_sum_frame_parser_top_assert.svh"

module slp_back #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  slp_pkg::buf_wr_t    wr,
  input  logic                q_empty,
  input  slp_pkg::frame_cmd_t q_head,
  output logic                q_pop,
  output logic                busy,
  output logic                res_valid,
  input  logic                res_stall,
  output slp_pkg::result_t    res
);

  localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [slp_pkg::BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [slp_pkg::BYTE_W-1:0] rdata;

  slp_pkg::back_state_t       bstate, bstate_next;
  slp_pkg::frame_cmd_t        cur, cur_next;
  logic [slp_pkg::LEN_W-1:0]  idx, idx_next;
  logic [slp_pkg::LEN_W-1:0]  idx_inc;
  logic                       rd_en;
  logic                       load_byte, load_empty;
  logic                       out_free;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rdata <= mem[idx[ADDR_W-1:0]];
    end
  end

  assign out_free = !res_valid || !res_stall;
  assign idx_inc  = idx + slp_pkg::LEN_W'(1);
  assign busy     = (bstate != slp_pkg::BK_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate <= slp_pkg::BK_IDLE;
    end else begin
      bstate <= bstate_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
  end

  always_comb begin
    bstate_next = bstate;
    cur_next    = cur;
    idx_next    = idx;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    load_byte   = 1'b0;
    load_empty  = 1'b0;
    unique case (bstate)
      slp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cur_next    = q_head;
          idx_next    = '0;
          bstate_next = (q_head.len == '0) ? slp_pkg::BK_EMPTY : slp_pkg::BK_FETCH;
        end
      end
      slp_pkg::BK_FETCH: begin
        rd_en       = 1'b1;
        bstate_next = slp_pkg::BK_LOAD;
      end
      slp_pkg::BK_LOAD: begin
        if (out_free) begin
          load_byte   = 1'b1;
          idx_next    = idx_inc;
          bstate_next = (idx_inc == cur.len) ? slp_pkg::BK_IDLE : slp_pkg::BK_FETCH;
        end
      end
      slp_pkg::BK_EMPTY: begin
        if (out_free) begin
          load_empty  = 1'b1;
          bstate_next = slp_pkg::BK_IDLE;
        end
      end
      default: bstate_next = slp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_byte || load_empty) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte || load_empty) begin
      res.msg_id     <= cur.id;
      res.data_len   <= cur.len;
      res.byte_index <= load_byte ? idx[slp_pkg::IDX_W-1:0] : '0;
      res.data_byte  <= load_byte ? rdata : '0;
      res.has_byte   <= load_byte;
      res.last       <= load_empty || (idx_inc == cur.len);
    end
  end

  `SLP_ASSERT_IMP(a_no_write_while_draining, wr.en, bstate == slp_pkg::BK_IDLE, "buffer written during drain")
  `SLP_ASSERT_IMP(a_empty_result_form, res_valid && !res.has_byte, res.last && (res.data_len == '0), "bad empty-frame result")
  `SLP_ASSERT_NXT(a_pop_starts_drain, q_pop, bstate != slp_pkg::BK_IDLE, "pop did not start a drain")

endmodule

>>> hdl/sync_length_sum_frame_parser_top.sv
// Top level of the sync / length-prefixed frame parser with 8-bit sum checksum.
// Parses frames sync_first, sync_second, id, length, payload, checksum from a
// byte stream (cmd 0) or a timeout (cmd 1, back to hunting). On a good
// checksum the payload is replayed one result per byte, with last set on the
// final one, and an empty payload gives one result with has_byte low. Each
// result comes from the fetch/load loop on the registered payload buffer
// read port, which loads one fetched byte before fetching the next. Header
// and checksum bytes of later frames keep flowing during a drain (up to two
// good frames queued), but payload bytes of a new frame stall until the
// buffer has drained. The buffer needs no clearing at reset. cfg_ready is
// always high; config writes are expected only while the block is idle.
module sync_length_sum_frame_parser_top #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slp_pkg::BYTE_W-1:0]    cfg_value,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  slp_pkg::item_t                item,
  output logic                          res_valid,
  input  logic                          res_stall,
  output slp_pkg::result_t              res
);

  slp_pkg::frame_cmd_t q_cmd, q_head;
  slp_pkg::buf_wr_t    wr;
  logic                q_push, q_pop, q_empty, q_full;
  logic                back_busy;

  assign cfg_ready = 1'b1;

  slp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_value  (cfg_value),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .drain_busy (back_busy || !q_empty),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd),
    .wr         (wr)
  );

  slp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  slp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> sim/tb.sv
// Testbench for the sync / length-prefixed frame parser with 8-bit sum checksum.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PAYLOAD = 32;
  localparam int DRAIN_GAP   = 16;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES  = 6;

  typedef struct packed {
    slp_pkg::item_t   it;
    logic             typed;
    slp_pkg::result_t want;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [slp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [slp_pkg::BYTE_W-1:0]    cfg_value;
  logic                          item_valid;
  logic                          item_stall;
  slp_pkg::item_t                item;
  logic                          res_valid;
  logic                          res_stall;
  slp_pkg::result_t              res;

  // parser copy kept by the testbench
  slp_pkg::phase_t            pstate;
  logic [slp_pkg::BYTE_W-1:0] cur_id;
  logic [slp_pkg::LEN_W-1:0]  cur_len;
  logic [slp_pkg::LEN_W-1:0]  fill_pos;
  logic [slp_pkg::BYTE_W-1:0] csum_acc;
  logic [slp_pkg::BYTE_W-1:0] pay_mem [MAX_PAYLOAD];
  logic [slp_pkg::BYTE_W-1:0] sync_a;
  logic [slp_pkg::BYTE_W-1:0] sync_b;

  slp_pkg::result_t pending_bytes [$];
  int               errors;
  int               phase_items;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               hold_req;
  int               hold_left;

  sync_length_sum_frame_parser_top #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_value  (cfg_value),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  always #2 clk = ~clk;

  function automatic void parse_byte(input slp_pkg::item_t x, input bit emit);
    logic [slp_pkg::BYTE_W-1:0] c;
    slp_pkg::result_t           r;
    c = x.rx_byte;
    if (x.cmd == slp_pkg::CMD_TIMEOUT) begin
      pstate = slp_pkg::PH_SYNC1;
      return;
    end
    case (pstate)
      slp_pkg::PH_SYNC2: begin
        pstate   = (c == sync_b) ? slp_pkg::PH_ID : slp_pkg::PH_SYNC1;
        csum_acc = csum_acc + c;
      end
      slp_pkg::PH_ID: begin
        cur_id   = c;
        csum_acc = csum_acc + c;
        pstate   = slp_pkg::PH_LEN;
      end
      slp_pkg::PH_LEN: begin
        if (c <= MAX_PAYLOAD) begin
          cur_len  = c[slp_pkg::LEN_W-1:0];
          fill_pos = '0;
          csum_acc = csum_acc + c;
          pstate   = (c > 0) ? slp_pkg::PH_DATA : slp_pkg::PH_CSUM;
        end else begin
          pstate = slp_pkg::PH_SYNC1;
        end
      end
      slp_pkg::PH_DATA: begin
        if (fill_pos < MAX_PAYLOAD) pay_mem[fill_pos[slp_pkg::IDX_W-1:0]] = c;
        fill_pos = fill_pos + 1'b1;
        csum_acc = csum_acc + c;
        if (fill_pos >= cur_len) pstate = slp_pkg::PH_CSUM;
      end
      slp_pkg::PH_CSUM: begin
        if (csum_acc == c && emit) begin
          r.msg_id   = cur_id;
          r.data_len = cur_len;
          if (cur_len == 0) begin
            r.byte_index = '0;
            r.data_byte  = '0;
            r.has_byte   = 1'b0;
            r.last       = 1'b1;
            pending_bytes.push_back(r);
          end else begin
            for (int i = 0; i < cur_len && i < MAX_PAYLOAD; i++) begin
              r.byte_index = i[slp_pkg::IDX_W-1:0];
              r.data_byte  = pay_mem[i[slp_pkg::IDX_W-1:0]];
              r.has_byte   = 1'b1;
              r.last       = (i + 1 == cur_len);
              pending_bytes.push_back(r);
            end
          end
        end
        pstate = slp_pkg::PH_SYNC1;
      end
      default: begin
        // any byte while hunting restarts the sum
        pstate   = (c == sync_a) ? slp_pkg::PH_SYNC2 : slp_pkg::PH_SYNC1;
        csum_acc = c;
      end
    endcase
  endfunction

  function automatic dir_row_t drow(input logic cmd, input logic [slp_pkg::BYTE_W-1:0] b,
                                    input logic typed = 1'b0,
                                    input slp_pkg::result_t want = '0);
    dir_row_t d;
    d.it.cmd     = cmd;
    d.it.rx_byte = b;
    d.typed      = typed;
    d.want       = want;
    return d;
  endfunction

  function automatic logic [slp_pkg::BYTE_W-1:0] rand_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(6));
    if (r < 90) return 8'($urandom_range(31, 7));
    return 8'(MAX_PAYLOAD);
  endfunction

  // one input transaction; valid is only lowered while idling
  task automatic push_item(input slp_pkg::item_t x, input bit use_want = 1'b0,
                           input slp_pkg::result_t want = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= x;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (use_want) begin
      parse_byte(x, 1'b0);
      pending_bytes.push_back(want);
    end else begin
      parse_byte(x, 1'b1);
    end
    phase_items++;
  endtask

  // cut: number of bytes sent before a timeout breaks the frame, -1 for none
  task automatic send_frame(input logic [slp_pkg::BYTE_W-1:0] len_byte, input bit bad_sum,
                            input int cut);
    logic [slp_pkg::BYTE_W-1:0] bytes [$];
    logic [slp_pkg::BYTE_W-1:0] sum;
    slp_pkg::item_t             x;
    int                         n;
    bytes.push_back(sync_a);
    bytes.push_back(sync_b);
    bytes.push_back(8'($urandom_range(255)));
    bytes.push_back(len_byte);
    if (len_byte <= MAX_PAYLOAD) begin
      repeat (len_byte) bytes.push_back(8'($urandom_range(255)));
      sum = '0;
      foreach (bytes[i]) sum = sum + bytes[i];
      bytes.push_back(bad_sum ? sum ^ (8'h01 << $urandom_range(7)) : sum);
    end
    n = (cut >= 0 && cut < bytes.size()) ? cut : bytes.size();
    for (int i = 0; i < n; i++) begin
      x.cmd     = slp_pkg::CMD_BYTE;
      x.rx_byte = bytes[i];
      push_item(x);
    end
    if (n < bytes.size()) begin
      x.cmd     = slp_pkg::CMD_TIMEOUT;
      x.rx_byte = 8'($urandom_range(255));
      push_item(x);
    end
  endtask

  task automatic load_syncs(input logic [slp_pkg::BYTE_W-1:0] s1,
                            input logic [slp_pkg::BYTE_W-1:0] s2);
    cfg_valid <= 1'b1;
    cfg_index <= slp_pkg::REG_SYNC_FIRST;
    cfg_value <= s1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= slp_pkg::REG_SYNC_SECOND;
    cfg_value <= s2;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sync_a = s1;
    sync_b = s2;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // result side: random stall, plus long hold-offs on request
  initial begin
    res_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // result checker
  initial begin
    slp_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (pending_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: id %h len %0d idx %0d byte %h has %b last %b",
                     res.msg_id, res.data_len, res.byte_index, res.data_byte,
                     res.has_byte, res.last);
        end else begin
          want = pending_bytes.pop_front();
          if (res !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp id %h len %0d idx %0d byte %h has %b last %b, ",
                       want.msg_id, want.data_len, want.byte_index, want.data_byte,
                       want.has_byte, want.last,
                       "got id %h len %0d idx %0d byte %h has %b last %b",
                       res.msg_id, res.data_len, res.byte_index, res.data_byte,
                       res.has_byte, res.last);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_row_t                   tab [$];
    slp_pkg::item_t             x;
    logic [slp_pkg::BYTE_W-1:0] s1;
    logic [slp_pkg::BYTE_W-1:0] s2;
    int                         r;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = slp_pkg::REG_SYNC_FIRST;
    cfg_value     = '0;
    item_valid    = 1'b0;
    item          = '0;
    errors        = 0;
    phase_items   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 0;
    pstate        = slp_pkg::PH_SYNC1;
    cur_id        = '0;
    cur_len       = '0;
    fill_pos      = '0;
    csum_acc      = '0;
    sync_a        = slp_pkg::SYNC_FIRST_RESET;
    sync_b        = slp_pkg::SYNC_SECOND_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty payload frame after reset
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAF));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h05));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h00));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h5E, 1'b1,
                       slp_pkg::result_t'{8'h05, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1}));
    // failed second sync is not retried as a first sync
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAF));
    // timeout mid-frame
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_TIMEOUT, 8'hFF));
    // length one above the limit
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAF));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h01));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h21));
    // all-ones id and payload
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAF));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hFF));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h01));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hFF));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h58, 1'b1,
                       slp_pkg::result_t'{8'hFF, 6'd1, 5'd0, 8'hFF, 1'b1, 1'b1}));
    // bad checksum, frame dropped
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAA));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'hAF));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h00));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h00));
    tab.push_back(drow(slp_pkg::CMD_BYTE, 8'h00));

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        item_valid <= 1'b0;
        wait_idle();
        case (p)
          1:       begin s1 = 8'h00; s2 = 8'hFF; end
          2:       begin s1 = 8'hFF; s2 = 8'h00; end
          3:       begin s1 = 8'($urandom_range(255)); s2 = 8'($urandom_range(255)); end
          4:       begin s1 = 8'h5A; s2 = 8'h5A; end
          default: begin s1 = slp_pkg::SYNC_FIRST_RESET; s2 = slp_pkg::SYNC_SECOND_RESET; end
        endcase
        load_syncs(s1, s2);
      end
      if (p < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 56;
      end else if (p < 4) begin
        send_idle_pct = 56;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_items = 0;
      if (p == 0) begin
        foreach (tab[i]) push_item(tab[i].it, tab[i].typed, tab[i].want);
        phase_items = 0;
      end
      if (p == 4) begin
        // long hold on results while full frames keep coming
        hold_req = 300;
        repeat (3) send_frame(8'(MAX_PAYLOAD), 1'b0, -1);
      end
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 68) begin
          send_frame(rand_len(), 1'b0, -1);
        end else if (r < 78) begin
          send_frame(rand_len(), 1'b1, -1);
        end else if (r < 84) begin
          send_frame(8'($urandom_range(255, MAX_PAYLOAD + 1)), 1'b0, -1);
        end else if (r < 90) begin
          send_frame(rand_len(), 1'b0, $urandom_range(6, 1));
        end else if (r < 96) begin
          x.cmd     = slp_pkg::CMD_BYTE;
          x.rx_byte = $urandom_range(1) ? sync_a : 8'($urandom_range(255));
          push_item(x);
        end else begin
          x.cmd     = slp_pkg::CMD_TIMEOUT;
          x.rx_byte = 8'($urandom_range(255));
          push_item(x);
        end
      end
    end

    item_valid <= 1'b0;
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/slp_pkg.sv
hdl/slp_front.sv
hdl/slp_queue.sv
hdl/slp_back.sv
hdl/sync_length_sum_frame_parser_top.sv
sim/tb.sv
